/* hw/rtl/msp_frame_encoder_assert.svh */
// Assertion macros used by the frame encoder top level.
`ifndef MSP_FRAME_ENCODER_ASSERT_SVH
`define MSP_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/msp_pkg.sv */
// Shared types and constants of the MSP v1 frame encoder.
`timescale 1ns / 1ps
package msp_pkg;

    // Status codes on the result channel
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FRAME   = 2'd1;
    localparam logic [1:0] ST_FRAME_OPEN = 2'd2;

    // Frame header characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // Input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Byte positions inside a job
    localparam int SEQ_W = 3;
    localparam logic [SEQ_W-1:0] IDX_DOLLAR = 3'd0;
    localparam logic [SEQ_W-1:0] IDX_M      = 3'd1;
    localparam logic [SEQ_W-1:0] IDX_DIR    = 3'd2;
    localparam logic [SEQ_W-1:0] IDX_LEN    = 3'd3;
    localparam logic [SEQ_W-1:0] IDX_CMD    = 3'd4;
    localparam logic [SEQ_W-1:0] IDX_CSUM   = 3'd5;
    localparam logic [SEQ_W-1:0] IDX_DATA   = 3'd0;
    localparam logic [SEQ_W-1:0] IDX_PCSUM  = 3'd1;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Job kinds produced by the front
    typedef enum logic [2:0] {
        K_HDR       = 3'd0,   // header, frame stays open
        K_HDR_CLOSE = 3'd1,   // header plus checksum, zero length
        K_PAY       = 3'd2,   // one payload byte
        K_PAY_CLOSE = 3'd3,   // last payload byte plus checksum
        K_ERR_OPEN  = 3'd4,   // start while frame open
        K_ERR_NOFRM = 3'd5    // payload with no frame open
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       dir;
        logic [7:0] byte_a;   // length or payload byte
        logic [7:0] byte_b;   // command
        logic [7:0] byte_c;   // checksum
    } t_job;

endpackage

/* hw/rtl/msp_frame_encoder.sv */
// Top level of the MSP v1 request frame encoder.
//
// channel   dir  handshake            payload
// input     in   push / full          i_op, i_command, i_payload_length, i_payload_byte
// result    out  empty / pop          o_out_byte, o_frame_end, o_run_last, o_status
// config    in   i_cfg_we             i_cfg_direction
//
// The front end takes one item per cycle while the four-entry job queue has room.
// The sequencer emits one result per cycle unless a held result stalls it; payload
// items give 1 or 2 results, starts 5 or 6, rejects 1; it sets the sustained rate.
// A job's result is registered in the result slot once the job is at the queue head and the slot is free or popped.
// Reset is synchronous, active low, and clears frame state, queue and result slot.
// A held result stalls the sequencer only; the front keeps taking items until full.
`timescale 1ns / 1ps
`include "msp_frame_encoder_assert.svh"
module msp_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_direction,
    input  logic       push,
    output logic       full,
    input  logic       i_op,
    input  logic [7:0] i_command,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_payload_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_run_last,
    output logic [1:0] o_status
);
    import msp_pkg::*;

    logic           r_direction;
    logic           w_accept;
    t_job           w_new_job;
    t_job           w_head_job;
    logic           w_head_valid;
    logic           w_job_done;
    logic [QCW-1:0] w_q_count;

    assign w_accept = push && !full;

    // Direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_direction;
        end
    end

    msp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_direction      (r_direction),
        .i_op             (i_op),
        .i_command        (i_command),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_job            (w_new_job)
    );

    msp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_job   (w_new_job),
        .o_full  (full),
        .i_rd    (w_job_done),
        .o_valid (w_head_valid),
        .o_job   (w_head_job),
        .o_count (w_q_count)
    );

    msp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_job_done  (w_job_done),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last),
        .o_status    (o_status)
    );

    // Checks
    `MSP_ASSERT_NOW(a_err_result, !empty && o_status != ST_OK, o_out_byte == 8'd0 && o_run_last && !o_frame_end, "rejected item result malformed")
    `MSP_ASSERT_NOW(a_end_is_last, !empty && o_frame_end, o_run_last, "checksum byte not last of its item")
    `MSP_ASSERT_NEXT(a_q_grow, w_accept && !w_job_done, w_q_count == $past(w_q_count) + QCW'(1), "job queue count lost a transfer")

endmodule

/* hw/rtl/msp_front.sv */
// Front end: accepts items, tracks frame state and issues jobs.
`timescale 1ns / 1ps
module msp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_direction,
    input  logic          i_op,
    input  logic [7:0]    i_command,
    input  logic [7:0]    i_payload_length,
    input  logic [7:0]    i_payload_byte,
    output msp_pkg::t_job o_job
);
    import msp_pkg::*;

    logic [7:0] r_running_xor, n_running_xor;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_frame_open, n_frame_open;
    logic [7:0] w_pay_xor;
    logic [7:0] w_left_dec;

    assign w_pay_xor  = r_running_xor ^ i_payload_byte;
    assign w_left_dec = r_bytes_left - 8'd1;

    // Classify the item and compute the next frame state
    always_comb begin
        n_running_xor = r_running_xor;
        n_bytes_left  = r_bytes_left;
        n_frame_open  = r_frame_open;
        o_job.dir     = i_direction;
        o_job.byte_a  = 8'd0;
        o_job.byte_b  = 8'd0;
        o_job.byte_c  = 8'd0;
        o_job.kind    = K_ERR_OPEN;
        if (i_op == OP_START) begin
            o_job.byte_a = i_payload_length;
            o_job.byte_b = i_command;
            o_job.byte_c = i_payload_length ^ i_command;
            if (r_frame_open) begin
                o_job.kind = K_ERR_OPEN;
            end else if (i_payload_length == 8'd0) begin
                o_job.kind    = K_HDR_CLOSE;
                n_running_xor = 8'd0;
                n_bytes_left  = 8'd0;
            end else begin
                o_job.kind    = K_HDR;
                n_running_xor = i_payload_length ^ i_command;
                n_bytes_left  = i_payload_length;
                n_frame_open  = 1'b1;
            end
        end else begin
            o_job.byte_a = i_payload_byte;
            o_job.byte_c = w_pay_xor;
            if (!r_frame_open) begin
                o_job.kind = K_ERR_NOFRM;
            end else if (w_left_dec == 8'd0) begin
                o_job.kind    = K_PAY_CLOSE;
                n_running_xor = 8'd0;
                n_bytes_left  = 8'd0;
                n_frame_open  = 1'b0;
            end else begin
                o_job.kind    = K_PAY;
                n_running_xor = w_pay_xor;
                n_bytes_left  = w_left_dec;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_xor <= 8'd0;
            r_bytes_left  <= 8'd0;
            r_frame_open  <= 1'b0;
        end else if (i_accept) begin
            r_running_xor <= n_running_xor;
            r_bytes_left  <= n_bytes_left;
            r_frame_open  <= n_frame_open;
        end
    end

endmodule

/* hw/rtl/msp_queue.sv */
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
module msp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  msp_pkg::t_job         i_job,
    output logic                  o_full,
    input  logic                  i_rd,
    output logic                  o_valid,
    output msp_pkg::t_job         o_job,
    output logic [msp_pkg::QCW-1:0] o_count
);
    import msp_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/msp_back.sv */
// Back end: walks each job byte by byte into the result register.
`timescale 1ns / 1ps
module msp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  msp_pkg::t_job i_job,
    output logic          o_job_done,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    o_out_byte,
    output logic          o_frame_end,
    output logic          o_run_last,
    output logic [1:0]    o_status
);
    import msp_pkg::*;

    logic [SEQ_W-1:0] r_idx;
    logic [SEQ_W-1:0] w_last_idx;
    logic             w_last;
    logic             w_adv;
    logic [7:0]       w_byte;
    logic             w_end;
    logic [1:0]       w_status;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_frame_end;
    logic             r_run_last;
    logic [1:0]       r_status;

    // Byte select per job kind and position
    always_comb begin
        w_byte     = 8'd0;
        w_end      = 1'b0;
        w_status   = ST_OK;
        w_last_idx = IDX_DATA;
        unique case (i_job.kind)
            K_HDR, K_HDR_CLOSE: begin
                w_last_idx = (i_job.kind == K_HDR_CLOSE) ? IDX_CSUM : IDX_CMD;
                case (r_idx)
                    IDX_DOLLAR: w_byte = CH_DOLLAR;
                    IDX_M:      w_byte = CH_M;
                    IDX_DIR:    w_byte = i_job.dir ? CH_GT : CH_LT;
                    IDX_LEN:    w_byte = i_job.byte_a;
                    IDX_CMD:    w_byte = i_job.byte_b;
                    IDX_CSUM: begin
                        w_byte = i_job.byte_c;
                        w_end  = 1'b1;
                    end
                    default:    w_byte = 8'd0;
                endcase
            end
            K_PAY: begin
                w_byte = i_job.byte_a;
            end
            K_PAY_CLOSE: begin
                w_last_idx = IDX_PCSUM;
                if (r_idx == IDX_PCSUM) begin
                    w_byte = i_job.byte_c;
                    w_end  = 1'b1;
                end else begin
                    w_byte = i_job.byte_a;
                end
            end
            K_ERR_OPEN:  w_status = ST_FRAME_OPEN;
            K_ERR_NOFRM: w_status = ST_NO_FRAME;
            default:     w_status = ST_OK;
        endcase
    end

    // Advance when a job is waiting and the result slot is free or drains
    assign w_last     = (r_idx == w_last_idx);
    assign w_adv      = i_job_valid && (!r_out_valid || pop);
    assign o_job_done = w_adv && w_last;

    // Position counter within the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_adv) begin
            r_idx <= w_last ? '0 : r_idx + SEQ_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte  <= w_byte;
            r_frame_end <= w_end;
            r_run_last  <= w_last;
            r_status    <= w_status;
        end
    end

    assign empty       = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_frame_end;
    assign o_run_last  = r_run_last;
    assign o_status    = r_status;

endmodule
